/* rtl/core/sct_pkg.sv */
// Shared types and constants of the saturation colouring tracker.
package sct_pkg;

	localparam int CNT_W = 7;
	localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;
	localparam logic [5:0] UNCOLORED = 6'd32;
	localparam int REPORT_COLORS = 32;

	typedef enum logic [2:0] {
		OP_CLEAR      = 3'd0,
		OP_SET_EDGE   = 3'd1,
		OP_SET_WEIGHT = 3'd2,
		OP_ASSIGN     = 3'd3,
		OP_UNASSIGN   = 3'd4,
		OP_QUERY      = 3'd5
	} op_t;

	typedef enum logic [0:0] {
		REG_NODES  = 1'b0,
		REG_COLORS = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_E_RDB,
		S_E_CHK,
		S_E_WRB,
		S_E_CNTB,
		S_E_CNTA,
		S_DRAIN,
		S_A_CHK,
		S_WALK_DN,
		S_WALK_UP,
		S_LOOK,
		S_LOOKW,
		S_SCAN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic clr;
		logic wr_weight;
		logic adj_rd;
		logic col_rd;
		logic rd_neigh;
		logic lat_a;
		logic lat_b;
		logic adj_wr_a;
		logic adj_wr_b;
		logic set_err;
		logic walk_start;
		logic walk_up;
		logic walk_step;
		logic rmw;
		logic rmw_to_neigh;
		logic look;
		logic lat_node;
		logic scan_start;
		logic scan_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       edge_go;
		logic       asg_ok;
		logic       unasg_ok;
		logic       old_colored;
		logic       walk_done;
		logic       scan_done;
		logic       out_free;
		logic       ca_col;
		logic       cb_col;
	} sts_t;

endpackage

/* rtl/core/saturation_coloring_tracker_top.sv */
// Top level of the saturation colouring tracker.
// One item at a time. An accepted assign or unassign walks all MAX_NODES rows of the store,
// a recolour walks them twice, and every item ends with a scan of the N nodes in use. The
// result beat is offered in the same cycle that the next item can be taken; a stalled result
// holds off the next result, and with it further input. Reset sets 64 nodes / 32 colours and
// empties stores via valid bits.
module saturation_coloring_tracker_top #(
	parameter int MAX_NODES  = 64,
	parameter int MAX_COLORS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [5:0]  node,
	input  logic [4:0]  color,
	input  logic [5:0]  neighbor,
	input  logic        edge_present,
	input  logic [15:0] weight,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [5:0]  node_color,
	output logic [5:0]  node_forbidden,
	output logic [31:0] node_feasible_mask,
	output logic [5:0]  next_node,
	output logic        next_valid,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	sct_pkg::cmd_t cmd;
	sct_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	sct_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	sct_dp #(.MAX_NODES(MAX_NODES), .MAX_COLORS(MAX_COLORS)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.op                (op),
		.node              (node),
		.color             (color),
		.neighbor          (neighbor),
		.edge_present      (edge_present),
		.weight            (weight),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.status            (status),
		.node_color        (node_color),
		.node_forbidden    (node_forbidden),
		.node_feasible_mask(node_feasible_mask),
		.next_node         (next_node),
		.next_valid        (next_valid),
		.cmd               (cmd),
		.sts               (sts)
	);

endmodule

/* rtl/core/sct_ram.sv */
// Generic simple dual-port RAM with registered read.
module sct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/sct_ctrl.sv */
// Sequencer for the colouring tracker: one item at a time.
module sct_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  sct_pkg::sts_t sts,
	output sct_pkg::cmd_t cmd
);

	sct_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sct_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != sct_pkg::S_IDLE);
		unique case (state_q)
			sct_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sct_pkg::S_DISP;
				end
			end
			sct_pkg::S_DISP: begin
				case (sts.op) inside
					sct_pkg::OP_CLEAR: begin
						cmd.clr = 1'b1;
						state_d = sct_pkg::S_LOOK;
					end
					sct_pkg::OP_SET_EDGE: begin
						cmd.adj_rd = 1'b1;
						cmd.col_rd = 1'b1;
						state_d    = sct_pkg::S_E_RDB;
					end
					sct_pkg::OP_SET_WEIGHT: begin
						cmd.wr_weight = 1'b1;
						state_d       = sct_pkg::S_LOOK;
					end
					sct_pkg::OP_ASSIGN, sct_pkg::OP_UNASSIGN: begin
						cmd.adj_rd = 1'b1;
						cmd.col_rd = 1'b1;
						state_d    = sct_pkg::S_A_CHK;
					end
					default: state_d = sct_pkg::S_LOOK;
				endcase
			end
			sct_pkg::S_E_RDB: begin
				cmd.lat_a    = 1'b1;
				cmd.adj_rd   = 1'b1;
				cmd.col_rd   = 1'b1;
				cmd.rd_neigh = 1'b1;
				state_d      = sct_pkg::S_E_CHK;
			end
			sct_pkg::S_E_CHK: begin
				cmd.lat_b = 1'b1;
				if (sts.edge_go) begin
					cmd.adj_wr_a = 1'b1;
					state_d      = sct_pkg::S_E_WRB;
				end else begin
					state_d = sct_pkg::S_LOOK;
				end
			end
			sct_pkg::S_E_WRB: begin
				cmd.adj_wr_b = 1'b1;
				state_d      = sct_pkg::S_E_CNTB;
			end
			sct_pkg::S_E_CNTB: begin
				cmd.rmw          = sts.ca_col;
				cmd.rmw_to_neigh = 1'b1;
				state_d          = sct_pkg::S_E_CNTA;
			end
			sct_pkg::S_E_CNTA: begin
				cmd.rmw = sts.cb_col;
				state_d = sct_pkg::S_DRAIN;
			end
			sct_pkg::S_DRAIN: state_d = sct_pkg::S_LOOK;
			sct_pkg::S_A_CHK: begin
				if (sts.op == sct_pkg::OP_ASSIGN) begin
					if (sts.asg_ok) begin
						cmd.walk_start = 1'b1;
						cmd.walk_up    = !sts.old_colored;
						state_d = sts.old_colored ? sct_pkg::S_WALK_DN : sct_pkg::S_WALK_UP;
					end else begin
						state_d = sct_pkg::S_LOOK;
					end
				end else if (sts.unasg_ok) begin
					cmd.walk_start = 1'b1;
					state_d        = sct_pkg::S_WALK_DN;
				end else begin
					cmd.set_err = 1'b1;
					state_d     = sct_pkg::S_LOOK;
				end
			end
			sct_pkg::S_WALK_DN: begin
				if (!sts.walk_done) begin
					cmd.walk_step = 1'b1;
				end else if (sts.op == sct_pkg::OP_ASSIGN) begin
					cmd.walk_start = 1'b1;
					cmd.walk_up    = 1'b1;
					state_d        = sct_pkg::S_WALK_UP;
				end else begin
					state_d = sct_pkg::S_DRAIN;
				end
			end
			sct_pkg::S_WALK_UP: begin
				if (!sts.walk_done) begin
					cmd.walk_step = 1'b1;
				end else begin
					state_d = sct_pkg::S_DRAIN;
				end
			end
			sct_pkg::S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = sct_pkg::S_LOOKW;
			end
			sct_pkg::S_LOOKW: begin
				cmd.lat_node   = 1'b1;
				cmd.scan_start = 1'b1;
				state_d        = sct_pkg::S_SCAN;
			end
			sct_pkg::S_SCAN: begin
				if (!sts.scan_done) begin
					cmd.scan_step = 1'b1;
				end else begin
					state_d = sct_pkg::S_OUT;
				end
			end
			sct_pkg::S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = sct_pkg::S_IDLE;
				end
			end
			default: state_d = sct_pkg::S_IDLE;
		endcase
	end

endmodule

/* rtl/core/sct_dp.sv */
// Datapath: graph stores, conflict-count RMW pipe, node scan and result register.
module sct_dp #(
	parameter int MAX_NODES  = 64,
	parameter int MAX_COLORS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [2:0]    op,
	input  logic [5:0]    node,
	input  logic [4:0]    color,
	input  logic [5:0]    neighbor,
	input  logic          edge_present,
	input  logic [15:0]   weight,
	input  logic          cfg_we,
	input  logic [0:0]    cfg_index,
	input  logic [6:0]    cfg_data,
	input  logic          out_stall,
	output logic          out_valid,
	output logic          status,
	output logic [5:0]    node_color,
	output logic [5:0]    node_forbidden,
	output logic [31:0]   node_feasible_mask,
	output logic [5:0]    next_node,
	output logic          next_valid,
	input  sct_pkg::cmd_t cmd,
	output sct_pkg::sts_t sts
);

	localparam int NW   = $clog2(MAX_NODES);
	localparam int NCW  = $clog2(MAX_NODES + 1);
	localparam int CIW  = $clog2(MAX_COLORS);
	localparam int FW   = $clog2(MAX_COLORS + 1);
	localparam int CW   = sct_pkg::CNT_W;
	localparam int RW   = MAX_COLORS * CW + FW;
	localparam int MW   = (MAX_COLORS < sct_pkg::REPORT_COLORS) ? MAX_COLORS
		: sct_pkg::REPORT_COLORS;

	logic [6:0]  nodes_q;
	logic [5:0]  colors_q;
	logic [2:0]  op_q;
	logic [5:0]  node_q, nb_q;
	logic [4:0]  color_q;
	logic        pres_q;
	logic [15:0] weight_q;

	logic [NCW-1:0] n_eff;
	logic [5:0]     c_eff;
	logic           node_in_n, nb_in_n, node_in_store;
	logic [NW-1:0]  node_ix, nb_ix, cnt_ix;

	logic [MAX_NODES-1:0] colored_q, rvalid_q, adj_v_q, wgt_v_q;
	logic [MAX_NODES-1:0] row_q, adj_row, row_mod_a, row_mod_b;
	logic                 adj_rd_v_q, wgt_rd_v_q;
	logic [4:0]           ca_q, cb_q;
	logic                 ca_col_q, cb_col_q;
	logic [CIW-1:0]       cur_color_q;
	logic                 up_q;
	logic [NCW-1:0]       cnt_q;
	logic                 err_q;

	logic          p_valid_s1;
	logic [NW-1:0] p_addr_s1;
	logic          sc_valid_s1;
	logic [NW-1:0] sc_idx_s1;

	logic [FW-1:0]  best_f_q;
	logic [15:0]    best_w_q;
	logic [NW-1:0]  best_idx_q;
	logic           best_valid_q;

	logic [5:0]  rep_color_q, rep_forb_q;
	logic [31:0] rep_mask_q;

	logic [MAX_NODES-1:0] adj_rdata;
	logic [4:0]           col_rdata;
	logic [15:0]          wgt_rdata;
	logic [RW-1:0]        cnt_rdata;

	logic [NW-1:0] rd_ix, cnt_raddr;
	logic          cnt_re;
	logic [RW-1:0] base_row, new_row;
	logic [CW-1:0] cur_cnt, new_cnt;
	logic [FW-1:0] cur_forb, new_forb, sc_forb;
	logic [15:0]   sc_w;
	logic          sc_better;
	logic [31:0]   look_mask;

	always_comb begin
		n_eff = (32'(nodes_q) < 32'(MAX_NODES)) ? NCW'(nodes_q) : NCW'(MAX_NODES);
		c_eff = (32'(colors_q) < 32'(MW)) ? colors_q : 6'(MW);
		node_in_n     = 32'(node_q) < 32'(n_eff);
		nb_in_n       = 32'(nb_q) < 32'(n_eff);
		node_in_store = 32'(node_q) < 32'(MAX_NODES);
		node_ix       = NW'(node_q);
		nb_ix         = NW'(nb_q);
		cnt_ix        = cnt_q[NW-1:0];
		rd_ix         = cmd.rd_neigh ? nb_ix : node_ix;
	end

	// configuration and item capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q  <= 7'd64;
			colors_q <= 6'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sct_pkg::REG_NODES:  nodes_q  <= cfg_data;
				sct_pkg::REG_COLORS: colors_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			node_q   <= node;
			color_q  <= color;
			nb_q     <= neighbor;
			pres_q   <= edge_present;
			weight_q <= weight;
		end
	end

	// adjacency rows
	assign adj_row = adj_rd_v_q ? adj_rdata : '0;

	always_comb begin
		row_mod_a        = row_q;
		row_mod_a[nb_ix] = pres_q;
		row_mod_b          = adj_row;
		row_mod_b[node_ix] = pres_q;
	end

	sct_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj (
		.clk    (clk),
		.we     (cmd.adj_wr_a || cmd.adj_wr_b),
		.waddr  (cmd.adj_wr_b ? nb_ix : node_ix),
		.wdata  (cmd.adj_wr_b ? row_mod_b : row_mod_a),
		.re     (cmd.adj_rd),
		.raddr  (rd_ix),
		.rdata_q(adj_rdata)
	);

	sct_ram #(.WIDTH(5), .DEPTH(MAX_NODES)) u_col (
		.clk    (clk),
		.we     (cmd.walk_start && cmd.walk_up),
		.waddr  (node_ix),
		.wdata  (color_q),
		.re     (cmd.col_rd || cmd.look),
		.raddr  (rd_ix),
		.rdata_q(col_rdata)
	);

	sct_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_wgt (
		.clk    (clk),
		.we     (cmd.wr_weight && node_in_n),
		.waddr  (node_ix),
		.wdata  (weight_q),
		.re     (cmd.scan_step),
		.raddr  (cnt_ix),
		.rdata_q(wgt_rdata)
	);

	always_comb begin
		if (cmd.walk_step || cmd.scan_step) begin
			cnt_raddr = cnt_ix;
		end else if (cmd.rmw && cmd.rmw_to_neigh) begin
			cnt_raddr = nb_ix;
		end else begin
			cnt_raddr = node_ix;
		end
		cnt_re = cmd.walk_step || cmd.scan_step || cmd.rmw || cmd.look;
	end

	sct_ram #(.WIDTH(RW), .DEPTH(MAX_NODES)) u_cnt (
		.clk    (clk),
		.we     (p_valid_s1),
		.waddr  (p_addr_s1),
		.wdata  (new_row),
		.re     (cnt_re),
		.raddr  (cnt_raddr),
		.rdata_q(cnt_rdata)
	);

	// conflict count update, write side of the RMW pipe
	always_comb begin
		base_row = rvalid_q[p_addr_s1] ? cnt_rdata : '0;
		cur_cnt  = base_row[32'(cur_color_q) * CW +: CW];
		cur_forb = base_row[RW-1 -: FW];
		new_cnt  = cur_cnt;
		new_forb = cur_forb;
		if (up_q) begin
			if (cur_cnt != sct_pkg::COUNT_MAX) begin
				new_cnt = cur_cnt + CW'(1);
			end
			if (cur_cnt == '0) begin
				new_forb = cur_forb + FW'(1);
			end
		end else if (cur_cnt != '0) begin
			new_cnt = cur_cnt - CW'(1);
			if (new_cnt == '0 && cur_forb != '0) begin
				new_forb = cur_forb - FW'(1);
			end
		end
		new_row = base_row;
		new_row[32'(cur_color_q) * CW +: CW] = new_cnt;
		new_row[RW-1 -: FW] = new_forb;
	end

	// scan compare
	always_comb begin
		sc_forb   = rvalid_q[sc_idx_s1] ? cnt_rdata[RW-1 -: FW] : '0;
		sc_w      = wgt_rd_v_q ? wgt_rdata : '0;
		sc_better = !best_valid_q || (sc_forb > best_f_q)
			|| (sc_forb == best_f_q && sc_w > best_w_q);
	end

	always_comb begin
		look_mask = '0;
		for (int i = 0; i < MW; i++) begin
			look_mask[i] = node_in_store && (6'(i) < c_eff)
				&& (!rvalid_q[node_ix] || cnt_rdata[i*CW +: CW] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colored_q    <= '0;
			rvalid_q     <= '0;
			adj_v_q      <= '0;
			wgt_v_q      <= '0;
			p_valid_s1   <= 1'b0;
			sc_valid_s1  <= 1'b0;
			cnt_q        <= '0;
			best_valid_q <= 1'b0;
			err_q        <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			p_valid_s1  <= 1'b0;
			sc_valid_s1 <= 1'b0;
			if (cmd.clr) begin
				colored_q <= '0;
				rvalid_q  <= '0;
			end
			if (p_valid_s1) begin
				rvalid_q[p_addr_s1] <= 1'b1;
			end
			if (cmd.walk_start) begin
				colored_q[node_ix] <= cmd.walk_up;
				cnt_q              <= '0;
			end
			if (cmd.adj_wr_a) begin
				adj_v_q[node_ix] <= 1'b1;
			end
			if (cmd.adj_wr_b) begin
				adj_v_q[nb_ix] <= 1'b1;
			end
			if (cmd.wr_weight && node_in_n) begin
				wgt_v_q[node_ix] <= 1'b1;
			end
			if (cmd.walk_step) begin
				p_valid_s1 <= row_q[0];
				cnt_q      <= cnt_q + NCW'(1);
			end
			if (cmd.rmw) begin
				p_valid_s1 <= 1'b1;
			end
			if (cmd.scan_start) begin
				cnt_q        <= '0;
				best_valid_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				sc_valid_s1 <= !colored_q[cnt_ix];
				cnt_q       <= cnt_q + NCW'(1);
			end
			if (sc_valid_s1 && sc_better) begin
				best_valid_q <= 1'b1;
			end
			if (cmd.load) begin
				err_q <= 1'b0;
			end else if (cmd.set_err) begin
				err_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.adj_rd) begin
			adj_rd_v_q <= adj_v_q[rd_ix];
		end
		if (cmd.scan_step) begin
			wgt_rd_v_q <= wgt_v_q[cnt_ix];
			sc_idx_s1  <= cnt_ix;
		end
		if (cmd.lat_a) begin
			row_q    <= adj_row;
			ca_q     <= col_rdata;
			ca_col_q <= colored_q[node_ix];
		end
		if (cmd.lat_b) begin
			cb_q     <= col_rdata;
			cb_col_q <= colored_q[nb_ix];
		end
		if (cmd.walk_start) begin
			row_q       <= adj_row;
			cur_color_q <= cmd.walk_up ? CIW'(color_q) : CIW'(col_rdata);
			up_q        <= cmd.walk_up;
		end
		if (cmd.walk_step) begin
			row_q     <= row_q >> 1;
			p_addr_s1 <= cnt_ix;
		end
		if (cmd.rmw) begin
			p_addr_s1   <= cmd.rmw_to_neigh ? nb_ix : node_ix;
			cur_color_q <= cmd.rmw_to_neigh ? CIW'(ca_q) : CIW'(cb_q);
			up_q        <= pres_q;
		end
		if (cmd.scan_start) begin
			best_idx_q <= '0;
		end
		if (sc_valid_s1 && sc_better) begin
			best_f_q   <= sc_forb;
			best_w_q   <= sc_w;
			best_idx_q <= sc_idx_s1;
		end
		if (cmd.lat_node) begin
			rep_color_q <= (node_in_store && colored_q[node_ix]) ? {1'b0, col_rdata}
				: sct_pkg::UNCOLORED;
			rep_forb_q  <= (node_in_store && rvalid_q[node_ix])
				? 6'(cnt_rdata[RW-1 -: FW]) : 6'd0;
			rep_mask_q  <= look_mask;
		end
		if (cmd.out_load) begin
			status             <= err_q;
			node_color         <= rep_color_q;
			node_forbidden     <= rep_forb_q;
			node_feasible_mask <= rep_mask_q;
			next_node          <= 6'(best_idx_q);
			next_valid         <= best_valid_q;
		end
	end

	always_comb begin
		sts.op          = op_q;
		sts.edge_go     = (node_q != nb_q) && node_in_n && nb_in_n
			&& (row_q[nb_ix] != pres_q);
		sts.asg_ok      = node_in_n && ({1'b0, color_q} < c_eff)
			&& !(colored_q[node_ix] && col_rdata == color_q);
		sts.unasg_ok    = node_in_n && colored_q[node_ix];
		sts.old_colored = colored_q[node_ix];
		sts.walk_done   = (cnt_q == NCW'(MAX_NODES));
		sts.scan_done   = (cnt_q == n_eff);
		sts.out_free    = !out_valid || !out_stall;
		sts.ca_col      = ca_col_q;
		sts.cb_col      = cb_col_q;
	end

	a_rmw_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(p_valid_s1 && cnt_re) |-> (cnt_raddr != p_addr_s1))
		else $error("count row read collides with pending write");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> (cnt_q < NCW'(MAX_NODES)))
		else $error("walk past last row");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result overwritten while stalled");

endmodule
